/* rtl/core/afr_pkg.sv */
// Shared types and constants for the addressed frame receiver.
package afr_pkg;

    // Frame framing bytes
    localparam logic [7:0] PREAMBLE_BYTE  = 8'hBC;
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

    // Per-byte event codes
    typedef enum logic [2:0] {
        EV_HUNT   = 3'd0,
        EV_ACCEPT = 3'd1,
        EV_GOOD   = 3'd2,
        EV_BADSUM = 3'd3,
        EV_REJECT = 3'd4
    } afr_event_t;

    // One result item as it leaves the parser
    typedef struct packed {
        afr_event_t  event_res;
        logic [5:0]  position;
        logic [7:0]  data_byte;
        logic [7:0]  seq_number;
        logic [6:0]  command;
        logic        ack_wanted;
        logic [5:0]  payload_len;
    } afr_result_t;

endpackage

/* rtl/core/afr_regs.sv */
// APB-style configuration register block (device address).
module afr_regs
    import afr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  device_address
);

    localparam logic REG_DEV_ADDR = 1'b0;

    logic [7:0] dev_addr_reg;
    logic       wr_en;
    logic       reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= 8'd1;
        end
        else if (wr_en && (reg_index == REG_DEV_ADDR))
        begin
            dev_addr_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_DEV_ADDR: prdata = {24'd0, dev_addr_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign device_address = dev_addr_reg;

endmodule

/* rtl/core/afr_parser.sv */
// Frame parser: position tracking, running checksum and header capture.
module afr_parser
    import afr_pkg::*;
#(
    parameter int FRAME_LIMIT  = 64,
    parameter int HEADER_BYTES = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  device_address,
    output afr_result_t result
);

    localparam int POS_W       = $clog2(FRAME_LIMIT);
    localparam int MAX_PAYLOAD = FRAME_LIMIT - HEADER_BYTES - 1;
    localparam bit LEN_ANY     = (MAX_PAYLOAD >= 0);
    localparam logic [7:0] LEN_MAX = LEN_ANY ? MAX_PAYLOAD[7:0] : 8'd0;
    localparam bit STORE_SEQ   = (HEADER_BYTES > 3);
    localparam bit STORE_CMD   = (HEADER_BYTES > 4);

    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ADDR = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SEQ  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CMD  = POS_W'(4);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       seq_reg, seq_next;
    logic [7:0]       cmd_reg, cmd_next;

    logic [7:0]       sum_add;
    logic [POS_W:0]   end_pos;
    logic             len_ok;
    afr_event_t       ev;
    logic [7:0]       seq_o;
    logic [7:0]       cmd_o;
    logic [POS_W-1:0] plen;
    logic [POS_W+5:0] pos_wide;
    logic [POS_W+5:0] plen_wide;

    assign sum_add = sum_reg + rx_byte;
    assign end_pos = (POS_W+1)'(HEADER_BYTES) + {1'b0, len_reg};
    assign len_ok  = LEN_ANY && (rx_byte <= LEN_MAX);

    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        sum_next = sum_reg;
        seq_next = seq_reg;
        cmd_next = cmd_reg;
        ev       = EV_ACCEPT;
        seq_o    = 8'd0;
        cmd_o    = 8'd0;
        plen     = '0;

        if (pos_reg == POS_HUNT)
        begin
            if (rx_byte == PREAMBLE_BYTE)
            begin
                sum_next = rx_byte;
                pos_next = POS_ADDR;
            end
            else
            begin
                ev = EV_HUNT;
            end
        end
        else if (pos_reg == POS_ADDR)
        begin
            if ((rx_byte == device_address) || (rx_byte == BROADCAST_ADDR))
            begin
                sum_next = sum_add;
                pos_next = POS_LEN;
            end
            else
            begin
                ev       = EV_REJECT;
                pos_next = POS_HUNT;
            end
        end
        else if (pos_reg == POS_LEN)
        begin
            if (len_ok)
            begin
                len_next = rx_byte[POS_W-1:0];
                sum_next = sum_add;
                pos_next = POS_SEQ;
                plen     = rx_byte[POS_W-1:0];
            end
            else
            begin
                ev       = EV_REJECT;
                pos_next = POS_HUNT;
            end
        end
        else if ({1'b0, pos_reg} == end_pos)
        begin
            // checksum byte closes the frame either way
            plen     = len_reg;
            pos_next = POS_HUNT;
            if (rx_byte == sum_reg)
            begin
                ev    = EV_GOOD;
                seq_o = seq_reg;
                cmd_o = cmd_reg;
            end
            else
            begin
                ev = EV_BADSUM;
            end
        end
        else
        begin
            if (STORE_SEQ && (pos_reg == POS_SEQ))
            begin
                seq_next = rx_byte;
            end
            if (STORE_CMD && (pos_reg == POS_CMD))
            begin
                cmd_next = rx_byte;
            end
            sum_next = sum_add;
            pos_next = pos_reg + 1'b1;
            plen     = len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
            sum_reg <= 8'd0;
            seq_reg <= 8'd0;
            cmd_reg <= 8'd0;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            sum_reg <= sum_next;
            seq_reg <= seq_next;
            cmd_reg <= cmd_next;
        end
    end

    // outputs are 6 bits wide whatever the internal position width
    assign pos_wide  = {6'd0, pos_reg};
    assign plen_wide = {6'd0, plen};

    assign result.event_res   = ev;
    assign result.position    = pos_wide[5:0];
    assign result.data_byte   = rx_byte;
    assign result.seq_number  = seq_o;
    assign result.command     = cmd_o[6:0];
    assign result.ack_wanted  = cmd_o[7];
    assign result.payload_len = plen_wide[5:0];

endmodule

/* rtl/core/addressed_frame_receiver.sv */
// Addressed frame receiver: top level with input and result registers.
//
// Usage:
//   Byte channel (byte_valid / byte_stall / rx_byte) takes received serial
//   bytes. Each transfer yields exactly one transfer on the event channel
//   (event_valid / event_stall and the result fields): the byte echoed with
//   its frame position; for the checksum byte a good-frame report with
//   sequence, command, ack bit and length, or a checksum-error report with length.
//   Frame: 0xBC, address (device_address or 0xFF), length, sequence,
//   command, payload, 8-bit additive checksum of all earlier bytes.
//   Path: a byte taken into the input register is parsed into the result
//   register, from which its event is offered on the event channel.
//   Throughput: one byte per cycle unless event_stall holds a full result
//   register; the only feedback path is the parser's position/checksum update.
//   Stall: when event_stall holds a full result register, the byte in the
//   input register waits and byte_stall rises; nothing is dropped.
//   Reset (rst_n low, async): both registers empty, parser hunting for a
//   preamble, device_address back to 1.
//   device_address is written over the APB-style port at byte address 0;
//   the user must write it only while no transfer is in flight, as the block itself has no check for it.
module addressed_frame_receiver
    import afr_pkg::*;
#(
    parameter int FRAME_LIMIT  = 64,
    parameter int HEADER_BYTES = 5
)
(
    input  logic        clk,
    input  logic        rst_n,

    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // byte channel
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rx_byte,

    // event channel
    output logic        event_valid,
    input  logic        event_stall,
    output logic [2:0]  event_res,
    output logic [5:0]  position,
    output logic [7:0]  data_byte,
    output logic [7:0]  seq_number,
    output logic [6:0]  command,
    output logic        ack_wanted,
    output logic [5:0]  payload_len
);

    logic [7:0]  device_address;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // result register
    logic        res_valid_reg;
    afr_result_t res_reg;

    afr_result_t parse_res;
    logic        out_ready;
    logic        advance;

    afr_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .device_address (device_address)
    );

    // result register free, or emptied by a transfer this cycle
    assign out_ready  = !res_valid_reg || !event_stall;
    assign advance    = in_valid_reg && out_ready;
    assign byte_stall = in_valid_reg && !out_ready;

    afr_parser #(
        .FRAME_LIMIT  (FRAME_LIMIT),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .rx_byte        (in_byte_reg),
        .device_address (device_address),
        .result         (parse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!byte_stall)
            begin
                in_valid_reg <= byte_valid;
            end
            if (out_ready)
            begin
                res_valid_reg <= advance;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            res_reg <= parse_res;
        end
    end

    assign event_valid = res_valid_reg;
    assign event_res   = res_reg.event_res;
    assign position    = res_reg.position;
    assign data_byte   = res_reg.data_byte;
    assign seq_number  = res_reg.seq_number;
    assign command     = res_reg.command;
    assign ack_wanted  = res_reg.ack_wanted;
    assign payload_len = res_reg.payload_len;

`ifndef SYNTH
    // frame info only accompanies a good frame
    a_info_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.event_res != EV_GOOD)) |->
        ((seq_number == 8'd0) && (command == 7'd0) && !ack_wanted))
        else $error("frame info set without good frame");

    // hunting and rejected bytes carry no length
    a_no_len_on_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && ((res_reg.event_res == EV_HUNT) ||
                           (res_reg.event_res == EV_REJECT))) |->
        (payload_len == 6'd0))
        else $error("length reported on dropped byte");

    // discarded bytes are only seen while hunting
    a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.event_res == EV_HUNT)) |-> (position == 6'd0))
        else $error("hunt event off position zero");

    // header rejects only happen on address or length bytes
    a_reject_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.event_res == EV_REJECT)) |->
        ((position == 6'd1) || (position == 6'd2)))
        else $error("reject outside header");

    // a byte waiting in the input register is never lost
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register dropped a byte");
`endif

endmodule

/* test/addressed_frame_receiver_test.sv */
// Testbench for the addressed frame receiver: random frames checked against a byte-level model.
`timescale 1ns / 1ps

module addressed_frame_receiver_test;
    import afr_pkg::*;

    // Parser geometry, matching the instance below
    localparam int FRAME_LIMIT  = 64;
    localparam int HEADER_BYTES = 5;
    localparam int MAX_PAYLOAD  = FRAME_LIMIT - HEADER_BYTES - 1;

    // Register map
    localparam logic [2:0] REG_DEVICE_ADDRESS = 3'd0;

    localparam int IDLE_PERCENT   = 23;
    localparam int HOLD_CYCLES    = 60;   // long receiver hold-off to back up the pipe
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no transfer at all
    localparam int PHASE_ITEMS    = 100;
    localparam int MAX_REPORTS    = 10;

    // ------------------------------------------------------------------
    // Frame parser model plus the queue of events still owed by the DUT
    // ------------------------------------------------------------------
    class frame_scoreboard;
        logic [7:0]  own_address;
        int          frame_pos;      // 0 means hunting for a preamble
        int          frame_len;
        logic [7:0]  running_total;
        logic [7:0]  seq_held;
        logic [7:0]  cmd_held;
        afr_result_t owed_events[$];
        int          failures;

        function new();
            own_address   = 8'd1;
            frame_pos     = 0;
            frame_len     = 0;
            running_total = '0;
            seq_held      = '0;
            cmd_held      = '0;
            failures      = 0;
        endfunction

        function void set_address(logic [7:0] addr);
            own_address = addr;
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        // Advance the parser by one accepted byte and queue the event it owes
        function void note_byte(logic [7:0] b);
            afr_result_t r;
            r           = '0;
            r.event_res = EV_ACCEPT;
            r.position  = frame_pos[5:0];
            r.data_byte = b;
            if (frame_pos == 0)
            begin
                if (b == PREAMBLE_BYTE)
                begin
                    running_total = b;
                    frame_pos     = 1;
                end
                else
                    r.event_res = EV_HUNT;
            end
            else if (frame_pos == 1)
            begin
                // rejected address byte is not looked at again as a preamble
                if (b == own_address || b == BROADCAST_ADDR)
                begin
                    running_total += b;
                    frame_pos      = 2;
                end
                else
                begin
                    r.event_res = EV_REJECT;
                    frame_pos   = 0;
                end
            end
            else if (frame_pos == 2)
            begin
                if (int'(b) > MAX_PAYLOAD)
                begin
                    r.event_res = EV_REJECT;
                    frame_pos   = 0;
                end
                else
                begin
                    frame_len      = int'(b);
                    running_total += b;
                    frame_pos      = 3;
                    r.payload_len  = frame_len[5:0];
                end
            end
            else if (frame_pos == HEADER_BYTES + frame_len)
            begin
                // checksum byte closes the frame either way
                r.payload_len = frame_len[5:0];
                if (b == running_total)
                begin
                    r.event_res  = EV_GOOD;
                    r.seq_number = seq_held;
                    r.command    = cmd_held[6:0];
                    r.ack_wanted = cmd_held[7];
                end
                else
                    r.event_res = EV_BADSUM;
                frame_pos = 0;
            end
            else
            begin
                // header fields only exist if the header is long enough
                if (frame_pos == 3 && frame_pos < HEADER_BYTES)
                    seq_held = b;
                if (frame_pos == 4 && frame_pos < HEADER_BYTES)
                    cmd_held = b;
                running_total += b;
                frame_pos      = frame_pos + 1;
                r.payload_len  = frame_len[5:0];
            end
            owed_events.push_back(r);
        endfunction

        function string describe(afr_result_t r);
            return $sformatf("ev=%0d pos=%0d byte=%02h seq=%02h cmd=%02h ack=%0b len=%0d",
                             r.event_res, r.position, r.data_byte, r.seq_number,
                             r.command, r.ack_wanted, r.payload_len);
        endfunction

        function void check_event(afr_result_t got);
            afr_result_t want;
            bit          wrong;
            if (owed_events.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: event with nothing owed: %s", $realtime, describe(got));
                return;
            end
            want  = owed_events.pop_front();
            wrong = (got.event_res  !== want.event_res)  ||
                    (got.position   !== want.position)   ||
                    (got.data_byte  !== want.data_byte)  ||
                    (got.seq_number !== want.seq_number) ||
                    (got.command    !== want.command)    ||
                    (got.ack_wanted !== want.ack_wanted) ||
                    (got.payload_len !== want.payload_len);
            if (wrong)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: event mismatch\n  expected %s\n  actual   %s",
                             $realtime, describe(want), describe(got));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        byte_valid  = 1'b0;
    logic        byte_stall;
    logic [7:0]  rx_byte     = '0;
    logic        event_valid;
    logic        event_stall = 1'b0;
    logic [2:0]  event_res;
    logic [5:0]  position;
    logic [7:0]  data_byte;
    logic [7:0]  seq_number;
    logic [6:0]  command;
    logic        ack_wanted;
    logic [5:0]  payload_len;

    addressed_frame_receiver #(
        .FRAME_LIMIT  (FRAME_LIMIT),
        .HEADER_BYTES (HEADER_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .rx_byte     (rx_byte),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_res   (event_res),
        .position    (position),
        .data_byte   (data_byte),
        .seq_number  (seq_number),
        .command     (command),
        .ack_wanted  (ack_wanted),
        .payload_len (payload_len)
    );

    frame_scoreboard sb = new();

    // Shared run control, written with NBAs so the other processes see it from the next edge on
    logic        quiet    = 1'b0;   // no idling on either side
    logic        hold_req = 1'b0;   // ask the receiver for one long hold-off
    bit          hold_served;
    int          hold_left;
    int          framed_items;      // bytes sent as part of frame traffic
    int          quiet_cycles;
    afr_result_t seen_event;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Event side: check every transfer, then pick the next stall value.
    // Outputs are sampled at the edge, before any NBA of that edge lands.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && event_valid && !event_stall)
        begin
            seen_event = '{event_res:  afr_event_t'(event_res),
                           position:   position,
                           data_byte:  data_byte,
                           seq_number: seq_number,
                           command:    command,
                           ack_wanted: ack_wanted,
                           payload_len: payload_len};
            sb.check_event(seen_event);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            event_stall <= 1'b1;
        end
        else if (hold_req && !hold_served)
        begin
            // sender keeps offering bytes meanwhile, so both registers fill
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES - 1;
            event_stall <= 1'b1;
        end
        else
            event_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Watchdog: any transfer on any port restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (event_valid && !event_stall) ||
                (psel && penable && pready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // One byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input bit counted);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= b;
        do
            @(posedge clk);
        while (!(byte_valid && !byte_stall));
        sb.note_byte(b);
        if (counted)
            framed_items++;
    endtask

    // Whole or cut-short frame; keep limits how many bytes go out
    task automatic send_frame(input logic [7:0] addr, input int len,
                              input logic [7:0] seq_b, input logic [7:0] cmd_b,
                              input bit corrupt, input int keep);
        logic [7:0] frame_bytes[$];
        logic [7:0] total;
        frame_bytes = '{PREAMBLE_BYTE, addr, 8'(len), seq_b, cmd_b};
        repeat (len)
            frame_bytes.push_back(8'($urandom));
        total = '0;
        foreach (frame_bytes[i])
            total += frame_bytes[i];
        if (corrupt)
            total ^= 8'($urandom_range(1, 255));
        frame_bytes.push_back(total);
        for (int i = 0; i < keep && i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], 1'b1);
    endtask

    // Setup cycle then access cycle; the write lands when pready is seen
    task automatic write_device_address(input logic [7:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DEVICE_ADDRESS;
        pwdata  <= {24'd0, addr};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_address(addr);
    endtask

    // Stop sending and let every owed event come out
    task automatic drain();
        byte_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    // Mostly well-formed frames with random content, plus broken headers,
    // cut-off frames and line noise
    task automatic run_random_phase(input int target);
        int         stop_at;
        int         pick;
        int         len;
        logic [7:0] stranger;
        logic [7:0] addr;
        stop_at = framed_items + target;
        // one maximum-length frame per phase
        send_frame(BROADCAST_ADDR, MAX_PAYLOAD, 8'($urandom), 8'($urandom), 1'b0, 255);
        while (framed_items < stop_at)
        begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                                : $urandom_range(0, 8);
            addr = ($urandom_range(0, 3) == 0) ? BROADCAST_ADDR : sb.own_address;
            if (pick < 65)
                send_frame(addr, len, 8'($urandom), 8'($urandom),
                           $urandom_range(0, 9) == 0, 255);
            else if (pick < 75)
                // cut short: whatever follows is taken as payload
                send_frame(addr, len, 8'($urandom), 8'($urandom), 1'b0,
                           $urandom_range(3, len + HEADER_BYTES));
            else if (pick < 85)
            begin
                do
                    stranger = 8'($urandom);
                while (stranger == sb.own_address || stranger == BROADCAST_ADDR);
                send_byte(PREAMBLE_BYTE, 1'b1);
                send_byte(stranger, 1'b1);
            end
            else if (pick < 92)
            begin
                send_byte(PREAMBLE_BYTE, 1'b1);
                send_byte(addr, 1'b1);
                send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b1);
            end
            else
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset address 1: hunting noise, good frame with ack bit,
        // bad checksum on broadcast, preamble as a wrong address (not retaken
        // as a preamble), lengths just over and far over the limit
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_frame(8'h01, 0, 8'hFF, 8'h80, 1'b0, 255);
        send_frame(BROADCAST_ADDR, 1, 8'h00, 8'h7F, 1'b1, 255);
        send_byte(PREAMBLE_BYTE, 1'b1);
        send_byte(PREAMBLE_BYTE, 1'b1);
        send_byte(PREAMBLE_BYTE, 1'b1);
        send_byte(BROADCAST_ADDR, 1'b1);
        send_byte(8'(MAX_PAYLOAD + 1), 1'b1);
        send_byte(PREAMBLE_BYTE, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain();

        // Address zero, with one long receiver hold-off early on
        write_device_address(8'h00);
        hold_req <= 1'b1;
        run_random_phase(PHASE_ITEMS);
        drain();

        // Own address equals broadcast; no idling anywhere
        write_device_address(8'hFF);
        quiet <= 1'b1;
        run_random_phase(PHASE_ITEMS);
        drain();
        quiet <= 1'b0;

        // Own address equals the preamble byte
        write_device_address(PREAMBLE_BYTE);
        run_random_phase(PHASE_ITEMS);
        drain();

        write_device_address(8'($urandom));
        run_random_phase(PHASE_ITEMS);
        drain();

        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/afr_pkg.sv
rtl/core/afr_regs.sv
rtl/core/afr_parser.sv
rtl/core/addressed_frame_receiver.sv
test/addressed_frame_receiver_test.sv
